// File: hw/rtl/tile_map_scroll_refresh_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tile map scroll refresh block
// Two concurrent assertion forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef TILE_MAP_SCROLL_REFRESH_TOP_MACROS_SVH
`define TILE_MAP_SCROLL_REFRESH_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge outside reset.
`define TMSR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that holds on the edge after a trigger.
`define TMSR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define TMSR_ASSERT_ALWAYS(lbl, cond, msg)
`define TMSR_ASSERT_NEXT(lbl, trig, cond, msg)
`endif

`endif

// File: hw/rtl/tmsr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmsr_pkg
// Types, constants and shared functions of the tile map scroll refresh block.
// ---------------------------------------------------------------------------
package tmsr_pkg;

  localparam int CAM_W = 11;

  localparam logic [7:0] SCREEN_TILES_W = 8'd20;
  localparam logic [7:0] SCREEN_TILES_H = 8'd18;

  // Full refresh covers the screen plus one extra column and row.
  localparam logic [4:0] FULL_W = 5'(SCREEN_TILES_W + 8'd1);
  localparam logic [4:0] FULL_H = 5'(SCREEN_TILES_H + 8'd1);

  localparam logic [7:0] MAP_W_RESET = 8'd156;
  localparam logic [7:0] MAP_H_RESET = 8'd66;
  localparam logic [7:0] TILE_NONE   = 8'd255;

  // Largest camera value any map size allows: (255 - 18) * 8.
  localparam logic [CAM_W-1:0] CAM_LIMIT = CAM_W'((9'd255 - 9'(SCREEN_TILES_H)) * 11'd8);

  // Configuration register indexes.
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // Result kinds.
  localparam logic KIND_SCROLL = 1'b0;
  localparam logic KIND_RECT   = 1'b1;

  // Input function codes.
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_INIT  = 1'b1;

  typedef struct packed {
    logic       func;
    logic       pad_up;
    logic       pad_down;
    logic       pad_left;
    logic       pad_right;
    logic [7:0] start_x;
    logic [7:0] start_y;
  } tmsr_req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] rect_x;
    logic [7:0] rect_y;
    logic [4:0] rect_w;
    logic [4:0] rect_h;
    logic       last;
  } tmsr_result_t;

  // Up to three results of one item; the one flagged last closes the group.
  typedef struct packed {
    tmsr_result_t [2:0] slot;
  } tmsr_bundle_t;

  // Camera maximum on one axis, zero when the map is no larger than the screen.
  function automatic logic [CAM_W-1:0] cam_max(input logic [7:0] map_tiles,
                                               input logic [7:0] screen_tiles);
    logic [7:0] diff;
    diff = map_tiles - screen_tiles;
    cam_max = (map_tiles > screen_tiles) ? {diff, 3'b000} : '0;
  endfunction

  // Tiles left before the map edge, capped at the given limit.
  function automatic logic [4:0] clip_len(input logic [4:0] limit,
                                          input logic [7:0] map_tiles,
                                          input logic [7:0] pos);
    logic [7:0] rem;
    rem = (map_tiles > pos) ? (map_tiles - pos) : 8'd0;
    clip_len = (rem < {3'b000, limit}) ? rem[4:0] : limit;
  endfunction

endpackage

// File: hw/rtl/tmsr_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmsr_req_if / tmsr_rsp_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface tmsr_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic       pad_up;
  logic       pad_down;
  logic       pad_left;
  logic       pad_right;
  logic [7:0] start_x;
  logic [7:0] start_y;

  modport source (output valid, func, pad_up, pad_down, pad_left, pad_right,
                  start_x, start_y, input ready);
  modport sink (input valid, func, pad_up, pad_down, pad_left, pad_right,
                start_x, start_y, output ready);
endinterface

interface tmsr_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] scroll_x;
  logic [7:0] scroll_y;
  logic [7:0] rect_x;
  logic [7:0] rect_y;
  logic [4:0] rect_w;
  logic [4:0] rect_h;
  logic       last;

  modport source (output valid, kind, scroll_x, scroll_y, rect_x, rect_y,
                  rect_w, rect_h, last, input ready);
  modport sink (input valid, kind, scroll_x, scroll_y, rect_x, rect_y,
                rect_w, rect_h, last, output ready);
endinterface

// File: hw/rtl/tmsr_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmsr_core
// Input register, camera state, map size registers and the single-pass
// logic that turns one item into a bundle of up to three results.
// ---------------------------------------------------------------------------
`include "tile_map_scroll_refresh_top_macros.svh"

module tmsr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data,
  tmsr_req_if.sink              req,
  output logic                  bnd_load,
  output tmsr_pkg::tmsr_bundle_t bnd,
  input  logic                  bnd_free
);

  logic                         req_valid;
  tmsr_pkg::tmsr_req_t          req_q;
  logic [7:0]                   map_w;
  logic [7:0]                   map_h;
  logic [tmsr_pkg::CAM_W-1:0]   cam_x;
  logic [tmsr_pkg::CAM_W-1:0]   cam_y;
  logic [7:0]                   prev_tile_col;
  logic [7:0]                   prev_tile_row;

  logic [tmsr_pkg::CAM_W-1:0]   max_x, max_y, init_x, init_y;
  logic [tmsr_pkg::CAM_W-1:0]   cam_x_next, cam_y_next;
  logic                         y_dec, y_inc, x_dec, x_inc, moved, emits, consume;
  logic [7:0]                   old_col, new_col, new_row, init_col, init_row;
  logic                         row_emit, col_emit;
  tmsr_pkg::tmsr_result_t       scroll_res, row_res, col_res, init_res;

  function automatic tmsr_pkg::tmsr_result_t make_scroll(
      input logic [tmsr_pkg::CAM_W-1:0] cx, input logic [tmsr_pkg::CAM_W-1:0] cy,
      input logic is_last);
    tmsr_pkg::tmsr_result_t r;
    r          = '0;
    r.kind     = tmsr_pkg::KIND_SCROLL;
    r.scroll_x = cx[7:0];
    r.scroll_y = cy[7:0];
    r.last     = is_last;
    return r;
  endfunction

  function automatic tmsr_pkg::tmsr_result_t make_rect(
      input logic [7:0] x, input logic [7:0] y, input logic [4:0] w,
      input logic [4:0] h, input logic is_last);
    tmsr_pkg::tmsr_result_t r;
    r        = '0;
    r.kind   = tmsr_pkg::KIND_RECT;
    r.rect_x = x;
    r.rect_y = y;
    r.rect_w = w;
    r.rect_h = h;
    r.last   = is_last;
    return r;
  endfunction

  always_comb begin
    max_x = tmsr_pkg::cam_max(map_w, tmsr_pkg::SCREEN_TILES_W);
    max_y = tmsr_pkg::cam_max(map_h, tmsr_pkg::SCREEN_TILES_H);

    // Init: clamp the start position into the map.
    init_x   = ({3'b000, req_q.start_x} > max_x) ? max_x : {3'b000, req_q.start_x};
    init_y   = ({3'b000, req_q.start_y} > max_y) ? max_y : {3'b000, req_q.start_y};
    init_col = init_x[10:3];
    init_row = init_y[10:3];

    // Frame: one pixel per axis, up over down and left over right.
    y_dec = req_q.pad_up && (cam_y != '0);
    y_inc = !req_q.pad_up && req_q.pad_down && (cam_y < max_y);
    x_dec = req_q.pad_left && (cam_x != '0);
    x_inc = !req_q.pad_left && req_q.pad_right && (cam_x < max_x);
    moved = y_dec || y_inc || x_dec || x_inc;

    cam_y_next = y_dec ? cam_y - 11'd1 : (y_inc ? cam_y + 11'd1 : cam_y);
    cam_x_next = x_dec ? cam_x - 11'd1 : (x_inc ? cam_x + 11'd1 : cam_x);

    old_col = cam_x[10:3];
    new_col = cam_x_next[10:3];
    new_row = cam_y_next[10:3];

    // A downward row or rightward column is only asked for while it lies in the map.
    row_emit = (new_row != prev_tile_row) &&
               (y_dec || ({1'b0, new_row} + 9'(tmsr_pkg::SCREEN_TILES_H) < {1'b0, map_h}));
    col_emit = (new_col != prev_tile_col) &&
               (x_dec || ({1'b0, new_col} + 9'(tmsr_pkg::SCREEN_TILES_W) < {1'b0, map_w}));

    scroll_res = make_scroll(cam_x_next, cam_y_next, !row_emit && !col_emit);
    row_res = make_rect(old_col,
                        y_dec ? new_row : new_row + tmsr_pkg::SCREEN_TILES_H,
                        tmsr_pkg::clip_len(tmsr_pkg::FULL_W, map_w, old_col),
                        5'd1, !col_emit);
    col_res = make_rect(x_dec ? new_col : new_col + tmsr_pkg::SCREEN_TILES_W,
                        new_row, 5'd1,
                        tmsr_pkg::clip_len(tmsr_pkg::FULL_H, map_h, new_row), 1'b1);
    init_res = make_rect(init_col, init_row,
                         tmsr_pkg::clip_len(tmsr_pkg::FULL_W, map_w, init_col),
                         tmsr_pkg::clip_len(tmsr_pkg::FULL_H, map_h, init_row), 1'b1);

    if (req_q.func == tmsr_pkg::FUNC_INIT) begin
      bnd.slot[0] = make_scroll(init_x, init_y, 1'b0);
      bnd.slot[1] = init_res;
      bnd.slot[2] = init_res;
    end else begin
      bnd.slot[0] = scroll_res;
      bnd.slot[1] = row_emit ? row_res : col_res;
      bnd.slot[2] = col_res;
    end

    emits    = (req_q.func == tmsr_pkg::FUNC_INIT) || moved;
    consume  = req_valid && (!emits || bnd_free);
    bnd_load = consume && emits;
  end

  assign req.ready = !req_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid     <= 1'b0;
      map_w         <= tmsr_pkg::MAP_W_RESET;
      map_h         <= tmsr_pkg::MAP_H_RESET;
      cam_x         <= '0;
      cam_y         <= '0;
      prev_tile_col <= tmsr_pkg::TILE_NONE;
      prev_tile_row <= tmsr_pkg::TILE_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmsr_pkg::REG_MAP_WIDTH:  map_w <= cfg_data;
          tmsr_pkg::REG_MAP_HEIGHT: map_h <= cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        req_valid <= 1'b1;
      end else if (consume) begin
        req_valid <= 1'b0;
      end
      if (consume) begin
        if (req_q.func == tmsr_pkg::FUNC_INIT) begin
          cam_x         <= init_x;
          cam_y         <= init_y;
          prev_tile_col <= tmsr_pkg::TILE_NONE;
          prev_tile_row <= tmsr_pkg::TILE_NONE;
        end else if (moved) begin
          cam_x         <= cam_x_next;
          cam_y         <= cam_y_next;
          prev_tile_col <= new_col;
          prev_tile_row <= new_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.func      <= req.func;
      req_q.pad_up    <= req.pad_up;
      req_q.pad_down  <= req.pad_down;
      req_q.pad_left  <= req.pad_left;
      req_q.pad_right <= req.pad_right;
      req_q.start_x   <= req.start_x;
      req_q.start_y   <= req.start_y;
    end
  end

  `TMSR_ASSERT_ALWAYS(a_cam_in_range, (cam_x <= tmsr_pkg::CAM_LIMIT) && (cam_y <= tmsr_pkg::CAM_LIMIT), "camera beyond largest map")
  `TMSR_ASSERT_NEXT(a_init_clears_tiles, consume && (req_q.func == tmsr_pkg::FUNC_INIT), (prev_tile_col == tmsr_pkg::TILE_NONE) && (prev_tile_row == tmsr_pkg::TILE_NONE), "init left a tile mark")
  `TMSR_ASSERT_NEXT(a_one_pixel_step, consume && (req_q.func == tmsr_pkg::FUNC_FRAME), (cam_x == $past(cam_x)) || (cam_x == $past(cam_x) + 11'd1) || (cam_x == $past(cam_x) - 11'd1), "camera x moved more than one pixel")

endmodule

// File: hw/rtl/tmsr_out.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tmsr_out
// Result register that holds one bundle and sends its results one per beat.
// ---------------------------------------------------------------------------
`include "tile_map_scroll_refresh_top_macros.svh"

module tmsr_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   bnd_load,
  input  tmsr_pkg::tmsr_bundle_t bnd,
  output logic                   bnd_free,
  tmsr_rsp_if.source             rsp
);

  logic                    out_valid;
  logic [1:0]              idx;
  tmsr_pkg::tmsr_bundle_t  bnd_q;
  tmsr_pkg::tmsr_result_t  cur;
  logic                    fire;

  assign cur      = bnd_q.slot[idx];
  assign fire     = out_valid && rsp.ready;
  assign bnd_free = !out_valid || (fire && cur.last);

  assign rsp.valid    = out_valid;
  assign rsp.kind     = cur.kind;
  assign rsp.scroll_x = cur.scroll_x;
  assign rsp.scroll_y = cur.scroll_y;
  assign rsp.rect_x   = cur.rect_x;
  assign rsp.rect_y   = cur.rect_y;
  assign rsp.rect_w   = cur.rect_w;
  assign rsp.rect_h   = cur.rect_h;
  assign rsp.last     = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (bnd_load) begin
      out_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire && cur.last) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (fire) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_load) begin
      bnd_q <= bnd;
    end
  end

  `TMSR_ASSERT_ALWAYS(a_load_when_free, !bnd_load || bnd_free, "bundle loaded over a pending one")
  `TMSR_ASSERT_ALWAYS(a_idx_in_range, !out_valid || (idx != 2'd3), "result index past the bundle")
  `TMSR_ASSERT_ALWAYS(a_third_is_last, !(out_valid && (idx == 2'd2)) || cur.last, "third result not flagged last")

endmodule

// File: hw/rtl/tile_map_scroll_refresh_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tile_map_scroll_refresh_top
// Camera over a tile map larger than the hardware map: emits scroll values
// and tile refresh rectangles for init and joypad frame items.
// ---------------------------------------------------------------------------
//  Channel   Dir   Beat contents
//  req       in    func, pad_up/down/left/right, start_x, start_y
//  rsp       out   kind, scroll_x/y, rect_x/y, rect_w/h, last
//  cfg       in    cfg_we, cfg_index, cfg_data (map width, map height)
//
// An item accepted on req is held in the input register; when the result
// register is free, its results are loaded there, and the rsp beats come from
// the result register. An item with n results occupies the result register
// for n beats (n is 0 to 3), and the next item is taken while those beats
// drain. Items that cause no result are consumed without waiting for the
// result register. A stall on rsp backs up through the result register into req.ready.
// Reset is synchronous; it clears the camera, the tile marks and the map size
// registers to their defaults.
// ---------------------------------------------------------------------------
module tile_map_scroll_refresh_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  tmsr_req_if.sink   req,
  tmsr_rsp_if.source rsp
);

  // Bundle handoff between the single-pass logic and the result register.
  logic                   bnd_load;
  logic                   bnd_free;
  tmsr_pkg::tmsr_bundle_t bnd;

  // Camera state, map size registers and per-item result computation.
  tmsr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .bnd_load  (bnd_load),
    .bnd       (bnd),
    .bnd_free  (bnd_free)
  );

  // Result register that sends one result per beat.
  tmsr_out u_out (
    .clk      (clk),
    .rst      (rst),
    .bnd_load (bnd_load),
    .bnd      (bnd),
    .bnd_free (bnd_free),
    .rsp      (rsp)
  );

endmodule
